// File: hw/rtl/qat_pkg.sv
// ============================================================================
// qat_pkg - shared types and constants for the quoted argument tokenizer
// Request payload layouts and the character codes that steer tokenizing.
// ============================================================================
`default_nettype none

package qat_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h27;
    localparam logic [7:0] ESCAPE_CHAR = 8'h5C;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] TAB_CHAR    = 8'h09;
    localparam logic [7:0] CR_CHAR     = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } qat_in_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       token_end;
        logic       message_end;
        logic       warn_open_quote;
        logic       warn_trailing_escape;
    } qat_out_t;

    // input register contents handed to the core
    typedef struct packed {
        logic    valid;
        qat_in_t item;
    } qat_hold_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qat_in_if.sv
// ============================================================================
// qat_in_if - input byte channel
// Valid/ready channel carrying one message byte and its last-byte mark.
// ============================================================================
`default_nettype none

interface qat_in_if;
    logic            valid;
    logic            ready;
    qat_pkg::qat_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qat_out_if.sv
// ============================================================================
// qat_out_if - result channel
// Valid/ready channel carrying one tokenizer result per input byte.
// ============================================================================
`default_nettype none

interface qat_out_if;
    logic              valid;
    logic              ready;
    qat_pkg::qat_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qat_in_stage.sv
// ============================================================================
// qat_in_stage - input register
// Captures one request per cycle unless the core stalls; refills in the same cycle the core drains it.
// ============================================================================
`default_nettype none

module qat_in_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    qat_in_if.sink               in_ch,
    input  wire                  take,
    output qat_pkg::qat_hold_t   hold
);

    logic             valid_reg;
    logic             valid_next;
    qat_pkg::qat_in_t item_reg;
    logic             accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_ch.data;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.item  = item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/qat_core.sv
// ============================================================================
// qat_core - tokenizer state and result register
// Applies one byte to the quote/escape/token state and registers the result.
// ============================================================================
`default_nettype none

module qat_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire qat_pkg::qat_hold_t hold,
    output logic                 take,
    qat_out_if.source            out_ch
);

    logic in_token_reg,  in_token_next;
    logic in_quotes_reg, in_quotes_next;
    logic escape_reg,    escape_next;
    logic has_bytes_reg, has_bytes_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    qat_pkg::qat_out_t res_reg;
    qat_pkg::qat_out_t res_next;

    logic [7:0] b;
    logic       last;
    logic       blank;
    logic       tok, quo, esc, hasb;

    assign take = hold.valid && (!out_valid_reg || out_ch.ready);
    assign b    = hold.item.in_byte;
    assign last = hold.item.msg_last;
    assign blank = qat_pkg::is_blank(b);

    always_comb
    begin
        tok  = in_token_reg;
        quo  = in_quotes_reg;
        esc  = escape_reg;
        hasb = has_bytes_reg;
        res_next = '0;

        if (escape_reg)
        begin
            esc  = 1'b0;
            hasb = 1'b1;
            res_next.byte_valid = 1'b1;
            res_next.out_byte   = b;
        end
        else if (!in_token_reg && blank)
        begin
            // skip whitespace between tokens
        end
        else if (in_token_reg && !in_quotes_reg && blank)
        begin
            res_next.token_end = 1'b1;
            tok  = 1'b0;
            hasb = 1'b0;
        end
        else
        begin
            tok = 1'b1;
            if (b == qat_pkg::QUOTE_CHAR)
            begin
                quo = !in_quotes_reg;
            end
            else if (b == qat_pkg::ESCAPE_CHAR)
            begin
                esc = 1'b1;
            end
            else
            begin
                hasb = 1'b1;
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = b;
            end
        end

        in_token_next  = tok;
        in_quotes_next = quo;
        escape_next    = esc;
        has_bytes_next = hasb;

        if (last)
        begin
            res_next.message_end = 1'b1;
            if (tok)
            begin
                // a lone trailing backslash only closes a token that has bytes
                res_next.warn_trailing_escape = esc;
                if (!esc || hasb)
                begin
                    res_next.token_end       = 1'b1;
                    res_next.warn_open_quote = quo;
                end
            end
            in_token_next  = 1'b0;
            in_quotes_next = 1'b0;
            escape_next    = 1'b0;
            has_bytes_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg  <= 1'b0;
            in_quotes_reg <= 1'b0;
            escape_reg    <= 1'b0;
            has_bytes_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                in_token_reg  <= in_token_next;
                in_quotes_reg <= in_quotes_next;
                escape_reg    <= escape_next;
                has_bytes_reg <= has_bytes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    // state fully cleared after the last byte of a message
    a_msg_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last) |=> (!in_token_reg && !in_quotes_reg && !escape_reg
                            && !has_bytes_reg))
        else $error("state not cleared after message end");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.byte_valid) |-> (res_reg.out_byte == 8'h00))
        else $error("out_byte nonzero without byte_valid");

    a_quote_warn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.warn_open_quote)
            |-> (res_reg.message_end && res_reg.token_end))
        else $error("open quote warning outside a closing message end");

    a_esc_warn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.warn_trailing_escape)
            |-> (res_reg.message_end && !res_reg.byte_valid))
        else $error("trailing escape warning on a non-final result");

    a_has_bytes_in_token: assert property (@(posedge clk) disable iff (!rst_n)
        has_bytes_reg |-> in_token_reg)
        else $error("token bytes recorded outside a token");

endmodule

`default_nettype wire

// File: hw/rtl/quoted_argument_tokenizer.sv
// ============================================================================
// quoted_argument_tokenizer - shell style argument splitter
// Splits a byte stream into tokens with single quotes and backslash escapes.
// ============================================================================
//
//  channel  dir  payload                                         handshake
//  in_ch    in   in_byte[7:0], msg_last                          valid/ready
//  out_ch   out  byte_valid, out_byte[7:0], token_end,           valid/ready
//                message_end, warn_open_quote, warn_trailing_escape
//
//  One request per cycle sustained while the output keeps accepting; an
//  accepted request is held in the input register, and its result is then
//  loaded into the result register, which drives the output handshake.
//  Throughput is bounded by the token state register update for each byte.
//  rst_n clears all valid flags and the token state; payload is not reset.
//  A stalled output holds its result; in_ch.ready drops only when both
//  registers are full and out_ch.ready is low.
// ============================================================================
`default_nettype none

module quoted_argument_tokenizer (
    input  wire     clk,
    input  wire     rst_n,
    qat_in_if.sink  in_ch,
    qat_out_if.source out_ch
);

    qat_pkg::qat_hold_t hold;
    logic               take;

    qat_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (take),
        .hold  (hold)
    );

    qat_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .hold   (hold),
        .take   (take),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - quoted argument tokenizer
// Directed messages cover blanks, quoting, escapes and warning cases, then
// about 1600 random bytes follow, mostly well-formed messages plus raw noise.
// Every result is checked field by field against an in-order prediction.
// ============================================================================

module testbench;

    logic clk;
    logic rst_n;

    qat_in_if  in_ch ();
    qat_out_if out_ch ();

    quoted_argument_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    qat_pkg::qat_in_t  pending_bytes[$];
    qat_pkg::qat_out_t split_results_due[$];

    // predicted splitter state
    logic tok_open;
    logic quote_open;
    logic escape_armed;
    logic tok_nonempty;

    int  bytes_sent = 0;
    int  mismatches = 0;
    wire quiet = (bytes_sent >= 500) && (bytes_sent < 900);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic qat_pkg::qat_out_t tokenize_step(input qat_pkg::qat_in_t req);
        qat_pkg::qat_out_t res;
        logic              blank;
        res   = '0;
        blank = (req.in_byte == qat_pkg::SPACE_CHAR) ||
                ((req.in_byte >= qat_pkg::TAB_CHAR) && (req.in_byte <= qat_pkg::CR_CHAR));
        if (escape_armed)
        begin
            escape_armed     = 1'b0;
            res.byte_valid   = 1'b1;
            res.out_byte     = req.in_byte;
            tok_nonempty     = 1'b1;
        end
        else if (!tok_open && blank)
        begin
            // blank between tokens, skipped
        end
        else if (tok_open && !quote_open && blank)
        begin
            res.token_end = 1'b1;
            tok_open      = 1'b0;
            tok_nonempty  = 1'b0;
        end
        else
        begin
            tok_open = 1'b1;
            if (req.in_byte == qat_pkg::QUOTE_CHAR)
                quote_open = ~quote_open;
            else if (req.in_byte == qat_pkg::ESCAPE_CHAR)
                escape_armed = 1'b1;
            else
            begin
                res.byte_valid = 1'b1;
                res.out_byte   = req.in_byte;
                tok_nonempty   = 1'b1;
            end
        end

        if (req.msg_last)
        begin
            res.message_end = 1'b1;
            if (tok_open)
            begin
                if (escape_armed)
                begin
                    res.warn_trailing_escape = 1'b1;
                    // a lone backslash with nothing before it closes nothing
                    if (tok_nonempty)
                    begin
                        res.token_end       = 1'b1;
                        res.warn_open_quote = quote_open;
                    end
                end
                else
                begin
                    res.token_end       = 1'b1;
                    res.warn_open_quote = quote_open;
                end
            end
            tok_open     = 1'b0;
            quote_open   = 1'b0;
            escape_armed = 1'b0;
            tok_nonempty = 1'b0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        qat_pkg::qat_in_t req;
        req.in_byte  = b;
        req.msg_last = last;
        pending_bytes = {pending_bytes, req};
    endtask

    task automatic push_msg(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_token_char();
        int          r;
        int          k;
        logic [7:0]  b;
        r = $urandom_range(99);
        if (r < 40)
            b = 8'(8'h61 + $urandom_range(25));
        else if (r < 56)
        begin
            k = $urandom_range(5);
            b = (k == 5) ? qat_pkg::SPACE_CHAR : 8'(qat_pkg::TAB_CHAR + k);
        end
        else if (r < 69)
            b = qat_pkg::QUOTE_CHAR;
        else if (r < 81)
            b = qat_pkg::ESCAPE_CHAR;
        else
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 7))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_bytes.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= quiet || ($urandom_range(99) >= 7);
    end

    // monitor: check results, then predict for the accepted request
    always @(posedge clk)
    begin
        qat_pkg::qat_out_t want;
        qat_pkg::qat_out_t pred;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (split_results_due.size() == 0)
                begin
                    $error("result arrived with none pending");
                    mismatches++;
                end
                else
                begin
                    want = split_results_due.pop_front();
                    check_field("byte_valid", 8'(want.byte_valid),
                                8'(out_ch.data.byte_valid));
                    check_field("out_byte", want.out_byte, out_ch.data.out_byte);
                    check_field("token_end", 8'(want.token_end),
                                8'(out_ch.data.token_end));
                    check_field("message_end", 8'(want.message_end),
                                8'(out_ch.data.message_end));
                    check_field("warn_open_quote", 8'(want.warn_open_quote),
                                8'(out_ch.data.warn_open_quote));
                    check_field("warn_trailing_escape", 8'(want.warn_trailing_escape),
                                8'(out_ch.data.warn_trailing_escape));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                pred = tokenize_step(in_ch.data);
                split_results_due = {split_results_due, pred};
                bytes_sent <= bytes_sent + 1;
            end
        end
    end

    initial
    begin
        int len;
        rst_n        = 1'b0;
        tok_open     = 1'b0;
        quote_open   = 1'b0;
        escape_armed = 1'b0;
        tok_nonempty = 1'b0;

        // directed messages
        push_msg(" ab\tc");           // leading blank, tab splits tokens
        push_msg("''");               // empty quoted token
        push_msg("'x ");              // blank inside quotes, quote left open
        push_msg("\\");               // lone backslash, nothing in token
        push_msg("'\\");              // lone backslash inside quotes, empty
        push_msg("a\\");              // trailing backslash after token bytes
        push_msg("\\'\\\\\\ ");       // escaped quote, backslash and space
        push_byte(8'h00, 1'b0);       // NUL and high bytes are plain bytes
        push_byte(8'hFF, 1'b1);
        push_msg("z\v\f\015\n");      // token ended by blank, then blanks only

        // random part: mostly messages from a token-heavy alphabet, some noise
        while (pending_bytes.size() < 1630)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                    push_byte(random_token_char(), i == len - 1);
            end
            else
            begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_ch.valid || split_results_due.size() != 0);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
